// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types and helpers for the ray/triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COORD_W = 20;             // Q12.8 coordinate
  localparam int DIV_STEPS = 21;           // quotient bits below the overflow bound
  localparam int SQ_W = 44;                // root bits of one area term
  localparam int RAD_W = 2 * SQ_W;         // radicand bits
  localparam int AREA_LAT = 6 + SQ_W;      // cycles through one area unit
  localparam int PIPE_LAT = 9 + DIV_STEPS + AREA_LAT;

  typedef logic signed [COORD_W-1:0] coord_t;

  // x sits in the low bits, matching the packed vertex registers
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  typedef logic [SQ_W-1:0]  root_t;
  typedef logic [RAD_W-1:0] rad_t;
  typedef logic [SQ_W+1:0]  sum_t;

  // trial subtrahend for root bit k: (root + 2^k)^2 - root^2
  function automatic rad_t sqrt_trial(root_t root, int k);
    rad_t trial;
    trial = (rad_t'(root) << (k + 1)) | (rad_t'(1) << (2 * k));
    return trial;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ray_triangle_intersect_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// One ray against one configured triangle: plane distance, hit point, and an
// area-sum inside test, fully pipelined.
// ----------------------------------------------------------------------------
// A request (start high while busy is low) is taken every cycle, one ray per
// clock, and its result appears on done in request order. The result passes
// through the restoring divider that forms the hit point and the 44-stage
// square-root pipelines of the four area units. done is a one-cycle strobe
// and the receiver cannot hold it off, so sample the result fields in that
// cycle. busy is high while reset is applied and for the first cycle after
// reset is released. Write the triangle registers only when no request is in
// flight; stages read the register values live.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [59:0]        cfg_data,
  input  logic signed [19:0] origin_x,
  input  logic signed [19:0] origin_y,
  input  logic signed [19:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic               done,
  output logic               hit,
  output logic signed [19:0] point_x,
  output logic signed [19:0] point_y,
  output logic signed [19:0] point_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [23:0]        hit_color
);

  typedef enum logic [2:0] {
    REG_VERTEX_A  = 3'd0,
    REG_VERTEX_B  = 3'd1,
    REG_VERTEX_C  = 3'd2,
    REG_NORMAL    = 3'd3,
    REG_MARGIN    = 3'd4,
    REG_TOLERANCE = 3'd5,
    REG_COLOR     = 3'd6
  } cfg_reg_t;

  typedef logic [53:0] num_t;   // |d * numer|
  typedef logic [32:0] den_t;   // |denom|
  typedef logic [rti_pkg::DIV_STEPS-1:0] quo_t;

  localparam int DS = rti_pkg::DIV_STEPS;
  localparam int AL = rti_pkg::AREA_LAT;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [59:0] vertex_a;
  logic [59:0] vertex_b;
  logic [59:0] vertex_c;
  logic [47:0] unit_normal;
  logic [15:0] parallel_margin;
  logic [19:0] area_tolerance;
  logic [23:0] surface_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a        <= '0;
      vertex_b        <= '0;
      vertex_c        <= '0;
      unit_normal     <= '0;
      parallel_margin <= 16'd16;
      area_tolerance  <= 20'd26;
      surface_color   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERTEX_A:  vertex_a        <= cfg_data;
        REG_VERTEX_B:  vertex_b        <= cfg_data;
        REG_VERTEX_C:  vertex_c        <= cfg_data;
        REG_NORMAL:    unit_normal     <= cfg_data[47:0];
        REG_MARGIN:    parallel_margin <= cfg_data[15:0];
        REG_TOLERANCE: area_tolerance  <= cfg_data[19:0];
        REG_COLOR:     surface_color   <= cfg_data[23:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  logic signed [19:0] vtx_a [3];
  logic signed [15:0] nrm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vtx_a[i] = vertex_a[20*i +: 20];
      nrm[i]   = unit_normal[16*i +: 16];
    end
  end

  // busy only covers reset; the pipeline never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Stages 1-3: capture the ray, then the two dot products n.d and n.(O-A)
  // --------------------------------------------------------------------------
  logic v1, v2, v3;
  logic signed [19:0] o1 [3];
  logic signed [19:0] o2 [3];
  logic signed [19:0] o3 [3];
  logic signed [15:0] d1 [3];
  logic signed [15:0] d2 [3];
  logic signed [15:0] d3 [3];
  logic signed [20:0] oa1 [3];
  logic signed [31:0] pd2 [3];
  logic signed [36:0] pn2 [3];
  logic signed [33:0] denom3;
  logic signed [38:0] numer3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oa1[i] = {o1[i][19], o1[i]} - {vtx_a[i][19], vtx_a[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
    o1[0] <= origin_x;
    o1[1] <= origin_y;
    o1[2] <= origin_z;
    d1[0] <= dir_x;
    d1[1] <= dir_y;
    d1[2] <= dir_z;
    for (int i = 0; i < 3; i++) begin
      pd2[i] <= nrm[i] * d1[i];
      pn2[i] <= nrm[i] * oa1[i];
    end
    o2 <= o1;
    d2 <= d1;
    denom3 <= pd2[0] + pd2[1] + pd2[2];
    numer3 <= pn2[0] + pn2[1] + pn2[2];
    o3 <= o2;
    d3 <= d2;
  end

  // --------------------------------------------------------------------------
  // Stages 4-5: miss checks, per-axis dividend d*numer, magnitudes and signs
  // --------------------------------------------------------------------------
  logic v4, v5;
  logic miss4, miss5;
  logic signed [19:0] o4 [3];
  logic signed [19:0] o5 [3];
  logic signed [54:0] dn4 [3];
  logic signed [54:0] dn_neg_c [3];
  logic dneg4;
  den_t dmag4, dmag5;
  num_t nmag5 [3];
  logic qneg5 [3];
  logic signed [33:0] denom_neg_c;
  den_t dmag_c;
  logic parallel_c;
  logic behind_c;

  always_comb begin
    denom_neg_c = -denom3;
    dmag_c = denom3[33] ? denom_neg_c[32:0] : denom3[32:0];
    parallel_c = dmag_c <= den_t'({parallel_margin, 14'b0});
    // plane behind the origin: nonzero terms of equal sign
    behind_c = (numer3 != '0) && (denom3 != '0) && (numer3[38] == denom3[33]);
    for (int i = 0; i < 3; i++) begin
      dn_neg_c[i] = -dn4[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= v3;
      v5 <= v4;
    end
    miss4 <= parallel_c || behind_c;
    dmag4 <= dmag_c;
    dneg4 <= denom3[33];
    o4 <= o3;
    for (int i = 0; i < 3; i++) begin
      dn4[i] <= d3[i] * numer3;
      nmag5[i] <= dn4[i][54] ? dn_neg_c[i][53:0] : dn4[i][53:0];
      qneg5[i] <= dn4[i][54] ^ dneg4;
    end
    miss5 <= miss4;
    dmag5 <= dmag4;
    o5 <= o4;
  end

  // --------------------------------------------------------------------------
  // Divider: stage 0 flags quotients of 2^21 and up, then one bit per stage
  // --------------------------------------------------------------------------
  num_t dv_rem [DS][3];
  quo_t dv_q   [DS+1][3];
  logic dv_ovf [DS+1][3];
  logic dv_neg [DS+1][3];
  logic signed [19:0] dv_o [DS+1][3];
  den_t dv_den [DS];
  logic dv_miss [DS+1];
  logic dv_v [DS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DS; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else begin
      dv_v[0] <= v5;
      for (int j = 1; j <= DS; j++) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
    dv_den[0]  <= dmag5;
    dv_miss[0] <= miss5;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= nmag5[i];
      dv_q[0][i]   <= '0;
      dv_ovf[0][i] <= nmag5[i] >= (num_t'(dmag5) << DS);
      dv_neg[0][i] <= qneg5[i];
      dv_o[0][i]   <= o5[i];
    end
    for (int j = 1; j <= DS; j++) begin
      if (j < DS) begin
        dv_den[j] <= dv_den[j-1];
      end
      dv_miss[j] <= dv_miss[j-1];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j-1][i] >= (num_t'(dv_den[j-1]) << (DS - j))) begin
          if (j < DS) begin
            dv_rem[j][i] <= dv_rem[j-1][i] - (num_t'(dv_den[j-1]) << (DS - j));
          end
          dv_q[j][i] <= dv_q[j-1][i] | (quo_t'(1) << (DS - j));
        end else begin
          if (j < DS) begin
            dv_rem[j][i] <= dv_rem[j-1][i];
          end
          dv_q[j][i] <= dv_q[j-1][i];
        end
        dv_ovf[j][i] <= dv_ovf[j-1][i];
        dv_neg[j][i] <= dv_neg[j-1][i];
        dv_o[j][i]   <= dv_o[j-1][i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Hit point: P = O - q, saturated to the coordinate range
  // --------------------------------------------------------------------------
  logic [21:0] qmag_c [3];
  logic [23:0] oext_c [3];
  logic [23:0] pt_c [3];
  rti_pkg::coord_t psat_c [3];
  rti_pkg::coord_t p_r [3];
  logic miss_p;
  logic v_p;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // an overflowed quotient stands in as 2^21, which saturates either way
      qmag_c[i] = dv_ovf[DS][i] ? 22'h20_0000 : {1'b0, dv_q[DS][i]};
      oext_c[i] = {{4{dv_o[DS][i][19]}}, dv_o[DS][i]};
      pt_c[i] = dv_neg[DS][i] ? oext_c[i] + {2'b00, qmag_c[i]}
                              : oext_c[i] - {2'b00, qmag_c[i]};
      if (pt_c[i][23:19] == 5'b00000 || pt_c[i][23:19] == 5'b11111) begin
        psat_c[i] = pt_c[i][19:0];
      end else if (pt_c[i][23]) begin
        psat_c[i] = 20'h8_0000;
      end else begin
        psat_c[i] = 20'h7_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else begin
      v_p <= dv_v[DS];
    end
    miss_p <= dv_miss[DS];
    p_r <= psat_c;
  end

  // --------------------------------------------------------------------------
  // Area units: full triangle and the three sub-triangles around P
  // --------------------------------------------------------------------------
  rti_pkg::vec3_t pv, av, bv, cv;
  rti_pkg::root_t m0, m1, m2, m3;

  assign pv = '{z: p_r[2], y: p_r[1], x: p_r[0]};
  assign av = rti_pkg::vec3_t'(vertex_a);
  assign bv = rti_pkg::vec3_t'(vertex_b);
  assign cv = rti_pkg::vec3_t'(vertex_c);

  rti_area u_area0 (.clk(clk), .lhs_a(bv), .lhs_b(av), .rhs_a(cv), .rhs_b(av), .mag(m0));
  rti_area u_area1 (.clk(clk), .lhs_a(pv), .lhs_b(av), .rhs_a(bv), .rhs_b(av), .mag(m1));
  rti_area u_area2 (.clk(clk), .lhs_a(pv), .lhs_b(bv), .rhs_a(cv), .rhs_b(bv), .mag(m2));
  rti_area u_area3 (.clk(clk), .lhs_a(pv), .lhs_b(cv), .rhs_a(av), .rhs_b(cv), .mag(m3));

  // hold point, miss and valid alongside the area units
  rti_pkg::coord_t dl_p [AL][3];
  logic dl_miss [AL];
  logic dl_v [AL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < AL; j++) begin
        dl_v[j] <= 1'b0;
      end
    end else begin
      dl_v[0] <= v_p;
      for (int j = 1; j < AL; j++) begin
        dl_v[j] <= dl_v[j-1];
      end
    end
    dl_p[0]    <= p_r;
    dl_miss[0] <= miss_p;
    for (int j = 1; j < AL; j++) begin
      dl_p[j]    <= dl_p[j-1];
      dl_miss[j] <= dl_miss[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // Area sum, tolerance compare and result register
  // --------------------------------------------------------------------------
  rti_pkg::sum_t sum_s, m0_s, dev_c;
  rti_pkg::coord_t sp [3];
  logic smiss, sv;
  logic hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else begin
      sv <= dl_v[AL-1];
    end
    sum_s <= rti_pkg::sum_t'(m1) + rti_pkg::sum_t'(m2) + rti_pkg::sum_t'(m3);
    m0_s  <= rti_pkg::sum_t'(m0);
    sp    <= dl_p[AL-1];
    smiss <= dl_miss[AL-1];
  end

  always_comb begin
    dev_c = (sum_s >= m0_s) ? sum_s - m0_s : m0_s - sum_s;
    hit_c = sv && !smiss && (dev_c <= rti_pkg::sum_t'({area_tolerance, 9'b0}));
  end

  // zero every field on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= sv;
      hit  <= hit_c;
    end
    point_x   <= hit_c ? sp[0] : '0;
    point_y   <= hit_c ? sp[1] : '0;
    point_z   <= hit_c ? sp[2] : '0;
    normal_x  <= hit_c ? nrm[0] : '0;
    normal_y  <= hit_c ? nrm[1] : '0;
    normal_z  <= hit_c ? nrm[2] : '0;
    hit_color <= hit_c ? surface_color : '0;
  end

endmodule
`default_nettype wire

// ===== sv/rti_area.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_area
// Pipelined |u x v| with u = lhs_a - lhs_b, v = rhs_a - rhs_b, floored root.
// ----------------------------------------------------------------------------
module rti_area (
  input  logic           clk,
  input  rti_pkg::vec3_t lhs_a,
  input  rti_pkg::vec3_t lhs_b,
  input  rti_pkg::vec3_t rhs_a,
  input  rti_pkg::vec3_t rhs_b,
  output rti_pkg::root_t mag
);

  logic signed [20:0] u_c [3];
  logic signed [20:0] v_c [3];
  logic signed [20:0] u_r [3];
  logic signed [20:0] v_r [3];
  logic signed [41:0] pr [6];
  logic signed [42:0] cx_c [3];
  logic signed [42:0] cneg_c [3];
  logic [41:0] cm [3];
  logic [41:0] hh [3];
  logic [41:0] hl [3];
  logic [41:0] ll [3];
  rti_pkg::rad_t sq [3];
  rti_pkg::rad_t rm [rti_pkg::SQ_W];
  rti_pkg::root_t rt [rti_pkg::SQ_W+1];

  always_comb begin
    u_c[0] = {lhs_a.x[19], lhs_a.x} - {lhs_b.x[19], lhs_b.x};
    u_c[1] = {lhs_a.y[19], lhs_a.y} - {lhs_b.y[19], lhs_b.y};
    u_c[2] = {lhs_a.z[19], lhs_a.z} - {lhs_b.z[19], lhs_b.z};
    v_c[0] = {rhs_a.x[19], rhs_a.x} - {rhs_b.x[19], rhs_b.x};
    v_c[1] = {rhs_a.y[19], rhs_a.y} - {rhs_b.y[19], rhs_b.y};
    v_c[2] = {rhs_a.z[19], rhs_a.z} - {rhs_b.z[19], rhs_b.z};
    for (int i = 0; i < 3; i++) begin
      cx_c[i] = {pr[2*i][41], pr[2*i]} - {pr[2*i+1][41], pr[2*i+1]};
      cneg_c[i] = -cx_c[i];
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_c;
    v_r <= v_c;
    // cross product terms
    pr[0] <= u_r[1] * v_r[2];
    pr[1] <= u_r[2] * v_r[1];
    pr[2] <= u_r[2] * v_r[0];
    pr[3] <= u_r[0] * v_r[2];
    pr[4] <= u_r[0] * v_r[1];
    pr[5] <= u_r[1] * v_r[0];
    for (int i = 0; i < 3; i++) begin
      cm[i] <= cx_c[i][42] ? cneg_c[i][41:0] : cx_c[i][41:0];
      // square split into 21-bit halves
      hh[i] <= cm[i][41:21] * cm[i][41:21];
      hl[i] <= cm[i][41:21] * cm[i][20:0];
      ll[i] <= cm[i][20:0] * cm[i][20:0];
      sq[i] <= (rti_pkg::rad_t'(hh[i]) << 42) + (rti_pkg::rad_t'(hl[i]) << 22)
               + rti_pkg::rad_t'(ll[i]);
    end
    rm[0] <= sq[0] + sq[1] + sq[2];
    rt[0] <= '0;
    // one root bit per stage, most significant first
    for (int j = 1; j <= rti_pkg::SQ_W; j++) begin
      if (rm[j-1] >= rti_pkg::sqrt_trial(rt[j-1], rti_pkg::SQ_W - j)) begin
        if (j < rti_pkg::SQ_W) begin
          rm[j] <= rm[j-1] - rti_pkg::sqrt_trial(rt[j-1], rti_pkg::SQ_W - j);
        end
        rt[j] <= rt[j-1] | (rti_pkg::root_t'(1) << (rti_pkg::SQ_W - j));
      end else begin
        if (j < rti_pkg::SQ_W) begin
          rm[j] <= rm[j-1];
        end
        rt[j] <= rt[j-1];
      end
    end
  end

  assign mag = rt[rti_pkg::SQ_W];

endmodule
`default_nettype wire

// ===== sv/rti_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks on request timing and result formatting.
// ----------------------------------------------------------------------------
module rti_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               hit,
  input logic signed [19:0] point_x,
  input logic signed [19:0] point_y,
  input logic signed [19:0] point_z,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic [23:0]        hit_color
);

  logic acc;
  assign acc = start && !busy && !rst;

  // hit only marks a delivered result
  a_hit_strobed: assert property (@(posedge clk) disable iff (rst) !done |-> !hit)
    else $error("hit without done");

  // a miss delivers all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> point_x == '0 && point_y == '0 && point_z == '0 &&
                     normal_x == '0 && normal_y == '0 && normal_z == '0 &&
                     hit_color == '0)
    else $error("miss result carries nonzero fields");

  // reset flushes results and blocks requests
  a_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("reset did not flush");

  // every request yields exactly one result at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##(rti_pkg::PIPE_LAT) done)
    else $error("result missing after request");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, rti_pkg::PIPE_LAT))
    else $error("result without request");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (.*);
`default_nettype wire

// ===== tb/ray_triangle_intersect_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top_tb
// Streams rays into the intersection pipeline and compares every result with
// an in-bench fixed-point model of the plane distance, the hit point and the
// area-sum inside test. The triangle registers are rewritten between phases.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top_tb;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam longint COORD_LO = -524288;
  localparam longint COORD_HI = 524287;

  typedef enum logic [2:0] {
    REG_VERTEX_A  = 3'd0,
    REG_VERTEX_B  = 3'd1,
    REG_VERTEX_C  = 3'd2,
    REG_NORMAL    = 3'd3,
    REG_MARGIN    = 3'd4,
    REG_TOLERANCE = 3'd5,
    REG_COLOR     = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_index_t;

  typedef struct {
    logic signed [19:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [19:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [23:0]        color;
  } hit_info_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [59:0]        cfg_data = '0;
  logic signed [19:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic               done;
  logic               hit;
  logic signed [19:0] point_x, point_y, point_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [23:0]        hit_color;

  // bench copy of the triangle registers
  logic [59:0] tri_a, tri_b, tri_c;
  logic [47:0] tri_normal;
  logic [15:0] tri_margin;
  logic [19:0] tri_tol;
  logic [23:0] tri_color;

  hit_info_t pending_hits[$];
  int        idle_pct = 0;
  int        error_count = 0;
  int        rays_sent = 0;
  int        results_seen = 0;
  int        hits_seen = 0;
  int        cycle_count = 0;

  ray_triangle_intersect_top uut (.*);

  always #2 clk = ~clk;

  // Hard stop if the pipeline ever stalls out.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("ray_triangle_intersect_top_tb: done, errors");
      $finish;
    end
  end

  function automatic longint unsigned twice_area(longint u0, longint u1, longint u2,
                                                 longint v0, longint v1, longint v2);
    longint c0, c1, c2;
    logic [127:0] a0, a1, a2, sq, trial_sq;
    logic [63:0] root, trial;
    c0 = u1 * v2 - u2 * v1;
    c1 = u2 * v0 - u0 * v2;
    c2 = u0 * v1 - u1 * v0;
    a0 = 128'(c0 < 0 ? -c0 : c0);
    a1 = 128'(c1 < 0 ? -c1 : c1);
    a2 = 128'(c2 < 0 ? -c2 : c2);
    sq = a0 * a0 + a1 * a1 + a2 * a2;
    root = '0;
    for (int b = 44; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      trial_sq = 128'(trial) * 128'(trial);
      if (trial_sq <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic longint coord_of(logic [59:0] packed_v, int k);
    logic signed [19:0] c;
    c = packed_v[20*k +: 20];
    return longint'(c);
  endfunction

  function automatic hit_info_t predict_hit(ray_t r);
    hit_info_t res;
    longint o[3], d[3], n[3], a[3], b[3], c[3], p[3];
    longint denom, numer, q, absd;
    longint unsigned m0, area_sum, dev;
    logic signed [15:0] nc;
    res = '{default: '0};
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    for (int k = 0; k < 3; k++) begin
      nc = tri_normal[16*k +: 16];
      n[k] = nc;
      a[k] = coord_of(tri_a, k);
      b[k] = coord_of(tri_b, k);
      c[k] = coord_of(tri_c, k);
    end
    denom = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
    absd = denom < 0 ? -denom : denom;
    if (absd <= (longint'(tri_margin) << 14)) return res;
    numer = n[0] * (o[0] - a[0]) + n[1] * (o[1] - a[1]) + n[2] * (o[2] - a[2]);
    if ((numer > 0 && denom > 0) || (numer < 0 && denom < 0)) return res;
    for (int k = 0; k < 3; k++) begin
      q = o[k] - (d[k] * numer) / denom;
      if (q < COORD_LO) q = COORD_LO;
      if (q > COORD_HI) q = COORD_HI;
      p[k] = q;
    end
    m0 = twice_area(b[0]-a[0], b[1]-a[1], b[2]-a[2], c[0]-a[0], c[1]-a[1], c[2]-a[2]);
    area_sum = twice_area(p[0]-a[0], p[1]-a[1], p[2]-a[2],
                          b[0]-a[0], b[1]-a[1], b[2]-a[2]);
    area_sum += twice_area(p[0]-b[0], p[1]-b[1], p[2]-b[2],
                           c[0]-b[0], c[1]-b[1], c[2]-b[2]);
    area_sum += twice_area(p[0]-c[0], p[1]-c[1], p[2]-c[2],
                           a[0]-c[0], a[1]-c[1], a[2]-c[2]);
    dev = area_sum >= m0 ? area_sum - m0 : m0 - area_sum;
    if (dev > (longint'(tri_tol) << 9)) return res;
    res.hit = 1'b1;
    res.px = 20'(p[0]); res.py = 20'(p[1]); res.pz = 20'(p[2]);
    res.nx = 16'(n[0]); res.ny = 16'(n[1]); res.nz = 16'(n[2]);
    res.color = tri_color;
    return res;
  endfunction

  // Hold the request until the pipeline takes it; start stays high afterward
  // so back-to-back requests never drop start within one step.
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    origin_x = r.ox; origin_y = r.oy; origin_z = r.oz;
    dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
    do @(posedge clk); while (busy);
    pending_hits.push_back(predict_hit(r));
    rays_sent++;
  endtask

  // Drain the pipeline before touching registers: stages read them live.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    wait (pending_hits.size() == 0);
    repeat (rti_pkg::PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [59:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_VERTEX_A:  tri_a = value;
      REG_VERTEX_B:  tri_b = value;
      REG_VERTEX_C:  tri_c = value;
      REG_NORMAL:    tri_normal = value[47:0];
      REG_MARGIN:    tri_margin = value[15:0];
      REG_TOLERANCE: tri_tol = value[19:0];
      REG_COLOR:     tri_color = value[23:0];
      default: ;
    endcase
  endtask

  function automatic logic [59:0] pack_vertex(longint x, longint y, longint z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  // Load a triangle and a unit normal worked out from its edges.
  task automatic set_triangle(logic [59:0] va, logic [59:0] vb, logic [59:0] vc,
                              logic [23:0] color);
    real e1[3], e2[3], cr[3], len;
    logic [15:0] nq[3];
    for (int k = 0; k < 3; k++) begin
      e1[k] = real'(coord_of(vb, k) - coord_of(va, k));
      e2[k] = real'(coord_of(vc, k) - coord_of(va, k));
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    len = $sqrt(cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]);
    for (int k = 0; k < 3; k++)
      nq[k] = (len == 0.0) ? 16'd0 : 16'($rtoi(cr[k] / len * 16383.0));
    write_reg(REG_VERTEX_A, va);
    write_reg(REG_VERTEX_B, vb);
    write_reg(REG_VERTEX_C, vc);
    write_reg(REG_NORMAL, {12'd0, nq[2], nq[1], nq[0]});
    write_reg(REG_COLOR, {36'd0, color});
  endtask

  function automatic longint clamp_coord(longint v);
    return v < COORD_LO ? COORD_LO : (v > COORD_HI ? COORD_HI : v);
  endfunction

  // Aim a ray from a random origin at a random point of the loaded triangle.
  function automatic ray_t aimed_ray(int spread);
    ray_t r;
    real w1, w2, tgt[3], org[3], len;
    w1 = $urandom_range(1000) / 1000.0;
    w2 = $urandom_range(1000) / 1000.0;
    if (w1 + w2 > 1.0) begin
      w1 = 1.0 - w1;
      w2 = 1.0 - w2;
    end
    for (int k = 0; k < 3; k++) begin
      tgt[k] = coord_of(tri_a, k) + w1 * (coord_of(tri_b, k) - coord_of(tri_a, k))
               + w2 * (coord_of(tri_c, k) - coord_of(tri_a, k));
      org[k] = real'(clamp_coord($rtoi(tgt[k]) + $signed($urandom_range(2*spread)) - spread));
    end
    len = $sqrt((tgt[0]-org[0])**2 + (tgt[1]-org[1])**2 + (tgt[2]-org[2])**2);
    if (len < 1.0) len = 1.0;
    r.ox = 20'($rtoi(org[0])); r.oy = 20'($rtoi(org[1])); r.oz = 20'($rtoi(org[2]));
    r.dx = 16'($rtoi((tgt[0]-org[0]) / len * 16000.0));
    r.dy = 16'($rtoi((tgt[1]-org[1]) / len * 16000.0));
    r.dz = 16'($rtoi((tgt[2]-org[2]) / len * 16000.0));
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.ox = 20'($urandom); r.oy = 20'($urandom); r.oz = 20'($urandom);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
    return r;
  endfunction

  function automatic ray_t make_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = 20'(ox); r.oy = 20'(oy); r.oz = 20'(oz);
    r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
    return r;
  endfunction

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  // Compare each strobed result with the oldest outstanding request.
  always @(posedge clk) begin
    hit_info_t e;
    if (!rst && done) begin
      results_seen++;
      if (pending_hits.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        e = pending_hits.pop_front();
        if (hit) hits_seen++;
        check_field("hit", e.hit, hit);
        check_field("point_x", e.px, point_x);
        check_field("point_y", e.py, point_y);
        check_field("point_z", e.pz, point_z);
        check_field("normal_x", e.nx, normal_x);
        check_field("normal_y", e.ny, normal_y);
        check_field("normal_z", e.nz, normal_z);
        check_field("hit_color", e.color, hit_color);
      end
    end
  end

  // Reset values: zero normal, so every ray is parallel and misses.
  task automatic test_reset_defaults;
    send_ray(make_ray(0, 0, 0, 16384, 0, 0));
    send_ray(noise_ray());
  endtask

  task automatic test_directed;
    // flat triangle in z = 0 with a simple axis normal
    write_reg(REG_VERTEX_A, pack_vertex(0, 0, 0));
    write_reg(REG_VERTEX_B, pack_vertex(25600, 0, 0));
    write_reg(REG_VERTEX_C, pack_vertex(0, 25600, 0));
    write_reg(REG_NORMAL, {12'd0, 16'sd16384, 16'sd0, 16'sd0});
    write_reg(REG_COLOR, 60'hFFFFFF);
    send_ray(make_ray(2560, 2560, 25600, 0, 0, -16384));     // straight hit
    send_ray(make_ray(2560, 2560, 25600, 0, 0, 16384));      // plane behind
    send_ray(make_ray(2560, 2560, 25600, 16384, 0, 0));      // parallel ray
    send_ray(make_ray(2560, 2560, 0, 16384, 0, 0));          // origin on plane
    send_ray(make_ray(2560, 2560, 0, 0, 0, -32768));         // origin on plane, steep
    send_ray(make_ray(30000, 30000, 25600, 0, 0, -16384));   // outside the triangle
    send_ray(make_ray(0, 0, 1000, 0, 0, -1000));             // at vertex A
    send_ray(make_ray(COORD_HI, COORD_HI, COORD_HI, -32768, -32768, -32768));
    send_ray(make_ray(COORD_LO, COORD_LO, COORD_LO, 32767, 32767, 32767));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    // near-parallel ray: zero margin lets it through and the point saturates
    write_reg(REG_MARGIN, 60'd0);
    send_ray(make_ray(0, 0, COORD_HI, 32767, 0, -1));
    send_ray(make_ray(0, 0, COORD_HI, -32768, -32768, -1));
    send_ray(make_ray(0, 0, COORD_HI, 0, 0, -1));
    // widest margin rejects everything
    write_reg(REG_MARGIN, 60'hFFFF);
    send_ray(make_ray(2560, 2560, 25600, 0, 0, -32768));
    write_reg(REG_MARGIN, 60'd16);
    // zero tolerance, then the widest tolerance with a point far outside the triangle
    write_reg(REG_TOLERANCE, 60'd0);
    send_ray(make_ray(2560, 2560, 25600, 0, 0, -16384));
    send_ray(make_ray(0, 0, 25600, 0, 0, -16384));
    write_reg(REG_TOLERANCE, 60'hFFFFF);
    send_ray(make_ray(400000, -400000, 25600, 0, 0, -16384));
    write_reg(REG_TOLERANCE, 60'd26);
    // degenerate triangle: all vertices on a line
    write_reg(REG_VERTEX_C, pack_vertex(51200, 0, 0));
    send_ray(make_ray(2560, 0, 25600, 0, 0, -16384));
    send_ray(make_ray(2560, 2560, 25600, 0, 0, -16384));
    // extreme vertices and an unused register index that must be ignored
    write_reg(REG_UNUSED, '1);
    write_reg(REG_VERTEX_A, pack_vertex(COORD_LO, COORD_LO, COORD_HI));
    write_reg(REG_VERTEX_B, pack_vertex(COORD_HI, COORD_LO, COORD_LO));
    write_reg(REG_VERTEX_C, pack_vertex(COORD_LO, COORD_HI, COORD_LO));
    write_reg(REG_NORMAL, {12'd0, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(REG_COLOR, 60'd0);
    send_ray(make_ray(0, 0, 0, 9000, 9000, 9000));
    send_ray(make_ray(COORD_HI, COORD_HI, COORD_HI, -9000, -9000, -9000));
  endtask

  // One random triangle per phase; most rays aimed, the rest raw noise.
  task automatic test_random_phase(int pct, int count);
    longint v[9];
    idle_pct = 0;
    for (int k = 0; k < 9; k++) v[k] = $signed($urandom_range(60000)) - 30000;
    set_triangle(pack_vertex(v[0], v[1], v[2]), pack_vertex(v[3], v[4], v[5]),
                 pack_vertex(v[6], v[7], v[8]), 24'($urandom));
    write_reg(REG_TOLERANCE, 60'($urandom_range(400)));
    write_reg(REG_MARGIN, 60'($urandom_range(64)));
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) send_ray(aimed_ray($urandom_range(1) ? 3000 : 60000));
      else send_ray(noise_ray());
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    tri_a = '0; tri_b = '0; tri_c = '0; tri_normal = '0;
    tri_margin = 16'd16; tri_tol = 20'd26; tri_color = '0;

    test_reset_defaults();
    test_directed();
    for (int ph = 0; ph < 9; ph++)
      test_random_phase(ph % 3 == 0 ? 0 : (ph % 3 == 1 ? 84 : 30), 50);

    drain();
    $display("Sent %0d rays, checked %0d results, %0d of them hits.",
             rays_sent, results_seen, hits_seen);
    $display("Covered reset defaults, directed corners and nine random triangles.");
    if (error_count == 0) begin
      $display("ray_triangle_intersect_top_tb: done, clean");
    end else begin
      $display("ray_triangle_intersect_top_tb: done, errors");
    end
    $finish;
  end

endmodule
